[hw/rtl/jfq_pkg.sv]
// ----------------------------------------------------------------------------
// jfq_pkg
// Shared constants, types and tables of the 8x8 forward DCT and quantizer.
// ----------------------------------------------------------------------------
package jfq_pkg;

  localparam int COEF_FRAC_BITS = 14;
  localparam int WORD_W = 24;

  // DCT constants rounded from Q30 to COEF_FRAC_BITS fraction bits
  localparam longint K30_NORM = 379625062;
  localparam longint K30_A = 526555088;
  localparam longint K30_B = 496004047;
  localparam longint K30_C = 446391849;
  localparam longint K30_D = 298269498;
  localparam longint K30_E = 205451603;
  localparam longint K30_F = 104738319;
  localparam longint RND30 = longint'(1) << (29 - COEF_FRAC_BITS);
  localparam int KW = COEF_FRAC_BITS + 2;
  localparam logic signed [KW-1:0] KN = KW'((K30_NORM + RND30) >>> (30 - COEF_FRAC_BITS));
  localparam logic signed [KW-1:0] KA = KW'((K30_A + RND30) >>> (30 - COEF_FRAC_BITS));
  localparam logic signed [KW-1:0] KB = KW'((K30_B + RND30) >>> (30 - COEF_FRAC_BITS));
  localparam logic signed [KW-1:0] KC = KW'((K30_C + RND30) >>> (30 - COEF_FRAC_BITS));
  localparam logic signed [KW-1:0] KD = KW'((K30_D + RND30) >>> (30 - COEF_FRAC_BITS));
  localparam logic signed [KW-1:0] KE = KW'((K30_E + RND30) >>> (30 - COEF_FRAC_BITS));
  localparam logic signed [KW-1:0] KF = KW'((K30_F + RND30) >>> (30 - COEF_FRAC_BITS));

  localparam logic [6:0] QUALITY_RESET = 7'd50;

  // controller to datapath commands
  typedef struct packed {
    logic       wr_sample;   // store sample at addr
    logic       load;        // load one element into the DCT input line
    logic [5:0] addr;        // work store address
    logic       write_back;  // write one DCT output
    logic [2:0] wb_k;        // which output
    logic       compute;     // run butterfly into output regs
    logic       mul_start;   // start multiply-accumulate sweep
    logic       quant_rd;    // read coefficient and step for quantizing
    logic       quant_calc;  // run the quantizer divide
  } jfq_cmd_t;

  typedef struct packed {
    logic mac_done;
    logic div_done;
  } jfq_status_t;

  function automatic logic [6:0] luma_base(input logic [5:0] i);
    logic [6:0] t [64];
    t = '{7'd16,7'd11,7'd10,7'd16,7'd24,7'd40,7'd51,7'd61,
          7'd12,7'd12,7'd14,7'd19,7'd26,7'd58,7'd60,7'd55,
          7'd14,7'd13,7'd16,7'd24,7'd40,7'd57,7'd69,7'd56,
          7'd14,7'd17,7'd22,7'd29,7'd51,7'd87,7'd80,7'd62,
          7'd18,7'd22,7'd37,7'd56,7'd68,7'd109,7'd103,7'd77,
          7'd24,7'd35,7'd55,7'd64,7'd81,7'd104,7'd113,7'd92,
          7'd49,7'd64,7'd78,7'd87,7'd103,7'd121,7'd120,7'd101,
          7'd72,7'd92,7'd95,7'd98,7'd112,7'd100,7'd103,7'd99};
    return t[i];
  endfunction

  function automatic logic [6:0] chroma_base(input logic [5:0] i);
    logic [6:0] r;
    case (i)
      6'd0: r = 7'd17;   6'd1: r = 7'd18;   6'd2: r = 7'd24;   6'd3: r = 7'd47;
      6'd8: r = 7'd18;   6'd9: r = 7'd21;   6'd10: r = 7'd26;  6'd11: r = 7'd66;
      6'd16: r = 7'd24;  6'd17: r = 7'd26;  6'd18: r = 7'd56;
      6'd24: r = 7'd47;  6'd25: r = 7'd66;
      default: r = 7'd99;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/jfq_if.sv]
// ----------------------------------------------------------------------------
// jfq stream interfaces
// Valid/ready channels for samples, results and the quality register.
// ----------------------------------------------------------------------------
interface jfq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  logic       is_chroma;
  modport source (output valid, sample, is_chroma, input ready);
  modport sink (input valid, sample, is_chroma, output ready);
endinterface

interface jfq_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         coeff_index;
  logic signed [11:0] level;
  logic signed [12:0] recon_value;
  logic               last;
  modport source (output valid, coeff_index, level, recon_value, last, input ready);
  modport sink (input valid, coeff_index, level, recon_value, last, output ready);
endinterface

interface jfq_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[hw/rtl/jfq_datapath.sv]
// ----------------------------------------------------------------------------
// jfq_datapath
// Work store, shared 8-point DCT unit with one multiplier, step computation
// and a serial divider for quantization.
// ----------------------------------------------------------------------------
module jfq_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  jfq_pkg::jfq_cmd_t    cmd,
  output jfq_pkg::jfq_status_t status,
  input  logic [7:0]           sample,
  input  logic                 table_sel,
  input  logic [6:0]           quality,
  output logic signed [11:0]   level,
  output logic signed [12:0]   recon_value
);
  import jfq_pkg::*;

  localparam int PW = WORD_W + KW + 4;

  logic signed [WORD_W-1:0] work_store [64];
  logic signed [WORD_W-1:0] rd_data;
  logic signed [WORD_W-1:0] x [8];
  logic signed [WORD_W-1:0] y [8];
  logic signed [WORD_W+2:0] e0, e1, e2, e3, d0, d1, d2, d3;
  logic signed [WORD_W+2:0] ea [8];
  logic signed [WORD_W+2:0] eb [8];
  logic signed [PW-1:0]     acc;
  logic signed [PW-1:0]     prod;
  logic [4:0]               mac_cnt;
  logic                     mac_busy;
  logic                     rd_pending;
  logic [2:0]               ld_k;

  // read the work store, registered
  always_ff @(posedge clk) begin
    if (cmd.wr_sample) begin
      work_store[cmd.addr] <= WORD_W'({16'd0, sample});
    end else if (cmd.write_back) begin
      work_store[cmd.addr] <= y[cmd.wb_k];
    end
    rd_data <= work_store[cmd.addr];
  end

  // shift registered read data into the input line as it arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      ld_k <= 3'd0;
    end else begin
      rd_pending <= cmd.load || cmd.quant_rd;
      if (rd_pending && !cmd.quant_calc) begin
        x[ld_k] <= rd_data;
        ld_k <= ld_k + 3'd1;
      end
    end
  end

  // butterfly front end
  always_comb begin
    logic signed [WORD_W+2:0] s0, s1, s2, s3;
    s0 = (WORD_W+3)'(x[0]) + (WORD_W+3)'(x[7]);
    s1 = (WORD_W+3)'(x[1]) + (WORD_W+3)'(x[6]);
    s2 = (WORD_W+3)'(x[2]) + (WORD_W+3)'(x[5]);
    s3 = (WORD_W+3)'(x[3]) + (WORD_W+3)'(x[4]);
    d0 = (WORD_W+3)'(x[0]) - (WORD_W+3)'(x[7]);
    d1 = (WORD_W+3)'(x[6]) - (WORD_W+3)'(x[1]);
    d2 = (WORD_W+3)'(x[2]) - (WORD_W+3)'(x[5]);
    d3 = (WORD_W+3)'(x[4]) - (WORD_W+3)'(x[3]);
    e0 = s0 + s3;
    e1 = s0 - s3;
    e2 = s1 + s2;
    e3 = s1 - s2;
  end

  // operand schedule: four product slots per output, summed over the sweep
  always_comb begin
    ea[0] = e0 + e2; eb[0] = '0;
    ea[4] = e0 - e2; eb[4] = '0;
    ea[2] = e1;      eb[2] = e3;
    ea[6] = e1;      eb[6] = -e3;
    ea[1] = d0;      eb[1] = -d1;
    ea[3] = d0;      eb[3] = d1;
    ea[5] = d0;      eb[5] = d1;
    ea[7] = d0;      eb[7] = d1;
  end

  // sixteen product terms for the odd outputs use four entries each; keep the
  // schedule as output-major: term t -> output t[4:2], index t[1:0]
  function automatic logic signed [KW-1:0] coef(input logic [4:0] t);
    logic signed [KW-1:0] r;
    case (t)
      5'd0:  r = KN;  5'd1: r = '0;  5'd2: r = '0;  5'd3: r = '0;
      5'd4:  r = KA;  5'd5: r = -KC; 5'd6: r = KD;  5'd7: r = -KF;
      5'd8:  r = KB;  5'd9: r = KE;  5'd10: r = '0; 5'd11: r = '0;
      5'd12: r = KC;  5'd13: r = KF; 5'd14: r = -KA; 5'd15: r = KD;
      5'd16: r = KN;  5'd17: r = '0; 5'd18: r = '0; 5'd19: r = '0;
      5'd20: r = KD;  5'd21: r = KA; 5'd22: r = KF; 5'd23: r = -KC;
      5'd24: r = KE;  5'd25: r = -KB; 5'd26: r = '0; 5'd27: r = '0;
      5'd28: r = KF;  5'd29: r = KD; 5'd30: r = KC; 5'd31: r = KA;
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [2:0] mo;
  logic [1:0] mj;
  logic signed [WORD_W+2:0] mop;
  assign mo = mac_cnt[4:2];
  assign mj = mac_cnt[1:0];
  always_comb begin
    case (mj)
      2'd0: mop = ea[mo];
      2'd1: mop = mo[0] ? d1 : eb[mo];
      2'd2: mop = d2;
      default: mop = d3;
    endcase
    if (!mo[0] && mj == 2'd1) mop = (mo == 3'd6) ? e3 : eb[mo];
    if (!mo[0] && mj[1]) mop = '0;
  end

  // multiply-accumulate sweep: one product per cycle, then round
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_busy <= 1'b0;
      mac_cnt <= 5'd0;
    end else if (cmd.mul_start) begin
      mac_busy <= 1'b1;
      mac_cnt <= 5'd0;
      acc <= '0;
    end else if (mac_busy) begin
      prod <= PW'(mop) * PW'(coef(mac_cnt));
      acc <= (mj == 2'd0) ? '0 : acc + prod;
      mac_cnt <= mac_cnt + 5'd1;
      if (mac_cnt == 5'd31) mac_busy <= 1'b0;
    end
  end

  // round a finished sum half away from zero as the next output begins
  logic signed [PW-1:0] tot;
  logic [PW-1:0]        mag;
  logic [PW-1:0]        rmag;
  logic [2:0]           done_o;
  logic                 tail;
  assign tot = acc + prod;
  assign mag = tot[PW-1] ? PW'(-tot) : PW'(tot);
  assign rmag = (mag + (PW'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
  assign done_o = tail ? 3'd7 : mo - 3'd1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tail <= 1'b0;
    end else begin
      tail <= mac_busy && mac_cnt == 5'd31;
    end
    if ((mac_busy && mj == 2'd0 && mac_cnt != 5'd0) || tail) begin
      y[done_o] <= tot[PW-1] ? WORD_W'(-rmag) : WORD_W'(rmag);
    end
  end

  // scaled step of the current coefficient: floor((2*num+den)/(2*den)) by a
  // serial divider, then the quantizer divide shares the same unit
  logic [6:0]  base;
  logic [19:0] num2;
  logic [19:0] den2;
  logic [19:0] rem;
  logic [19:0] quo;
  logic [4:0]  dcnt;
  logic [1:0]  dphase;
  logic [7:0]  step;
  logic signed [WORD_W-1:0] coef_v;
  logic neg;
  logic [19:0] trial;
  logic        qbit;
  logic [19:0] rem_next;
  logic [19:0] quo_next;
  logic [7:0]  step_c;
  logic [WORD_W-1:0] cmag;
  assign base = table_sel ? chroma_base(cmd.addr) : luma_base(cmd.addr);

  // one restoring division bit
  assign trial = {rem[18:0], num2[dcnt]};
  assign qbit = (trial >= den2);
  assign rem_next = qbit ? trial - den2 : trial;
  assign quo_next = {quo[18:0], qbit};
  assign step_c = (quo_next == 20'd0) ? 8'd1 : (quo_next > 20'd255) ? 8'd255 : quo_next[7:0];
  assign cmag = coef_v[WORD_W-1] ? WORD_W'(-coef_v) : WORD_W'(coef_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      dphase <= 2'd0;
      dcnt <= 5'd0;
    end else begin
      case (dphase)
        2'd0: begin
          if (cmd.quant_calc) begin
            coef_v <= rd_data;
            if (quality < 7'd50) begin
              num2 <= 20'(2 * 50 * base) + 20'(quality);
              den2 <= 20'(2 * quality);
            end else begin
              num2 <= 20'(2 * base * (7'd100 - quality)) + 20'd50;
              den2 <= 20'd100;
            end
            rem <= '0;
            quo <= '0;
            dcnt <= 5'd19;
            dphase <= 2'd1;
          end
        end
        2'd1, 2'd2: begin
          if (dphase == 2'd1 && dcnt == 5'd0) begin
            // step known: set up level = (2*|c|+step)/(2*step)
            step <= step_c;
            neg <= coef_v[WORD_W-1];
            num2 <= 20'(2 * cmag) + 20'(step_c);
            den2 <= {11'd0, step_c, 1'b0};
            rem <= '0;
            quo <= '0;
            dcnt <= 5'd19;
            dphase <= 2'd2;
          end else begin
            // advance the division one bit
            rem <= rem_next;
            quo <= quo_next;
            if (dcnt == 5'd0) begin
              dphase <= 2'd3;
            end else begin
              dcnt <= dcnt - 5'd1;
            end
          end
        end
        default: dphase <= 2'd0;
      endcase
    end
  end

  // saturate and rescale the finished level
  logic [19:0] lvm;
  logic [11:0] lvs;
  logic [19:0] rvm;
  assign lvm = (quo > 20'd2040) ? 20'd2040 : quo;
  assign lvs = lvm[11:0];
  assign rvm = (20'(lvs) * 20'(step) > 20'd2200) ? 20'd2200 : 20'(lvs) * 20'(step);
  always_ff @(posedge clk) begin
    if (dphase == 2'd3) begin
      level <= neg ? -$signed(lvs) : $signed(lvs);
      recon_value <= neg ? -$signed(rvm[12:0]) : $signed(rvm[12:0]);
    end
  end
  assign status = '{mac_done: tail, div_done: (dphase == 2'd3)};

endmodule

[hw/rtl/jfq_ctrl.sv]
// ----------------------------------------------------------------------------
// jfq_ctrl
// Sequencer: sample collection, sixteen DCT passes, 64 quantize steps.
// ----------------------------------------------------------------------------
module jfq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_chroma,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [5:0]           out_index,
  output logic                 table_sel,
  output jfq_pkg::jfq_cmd_t    cmd,
  input  jfq_pkg::jfq_status_t status
);
  import jfq_pkg::*;

  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_LOAD    = 3'd1;
  localparam logic [2:0] S_MAC     = 3'd2;
  localparam logic [2:0] S_WB      = 3'd3;
  localparam logic [2:0] S_QRD     = 3'd4;
  localparam logic [2:0] S_QDIV    = 3'd5;
  localparam logic [2:0] S_OUT     = 3'd6;

  logic [2:0] state;
  logic [5:0] count;
  logic [3:0] pass;
  logic [3:0] k;
  logic       mac_go;

  // element address of position j in the current pass
  function automatic logic [5:0] pos(input logic [3:0] p, input logic [2:0] j);
    return p[3] ? {j, p[2:0]} : {p[2:0], j};
  endfunction

  assign in_ready = (state == S_COLLECT);
  assign out_valid = (state == S_OUT);
  assign out_index = count;

  always_comb begin
    cmd = '0;
    cmd.addr = count;
    case (state)
      S_COLLECT: cmd.wr_sample = in_valid;
      S_LOAD: begin
        cmd.addr = pos(pass, k[2:0]);
        cmd.load = !k[3];
        cmd.mul_start = k == 4'd9;
      end
      S_WB: begin
        cmd.addr = pos(pass, k[2:0]);
        cmd.write_back = 1'b1;
        cmd.wb_k = k[2:0];
      end
      S_QRD: cmd.quant_rd = 1'b1;
      S_QDIV: cmd.quant_calc = mac_go;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
      count <= 6'd0;
      pass <= 4'd0;
      k <= 4'd0;
      mac_go <= 1'b0;
      table_sel <= 1'b0;
    end else begin
      case (state)
        S_COLLECT: begin
          if (in_valid) begin
            count <= count + 6'd1;
            if (count == 6'd63) begin
              table_sel <= in_chroma;
              pass <= 4'd0;
              k <= 4'd0;
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          k <= k + 4'd1;
          if (k == 4'd9) state <= S_MAC;
        end
        S_MAC: begin
          k <= 4'd0;
          if (status.mac_done) state <= S_WB;
        end
        S_WB: begin
          k <= k + 4'd1;
          if (k == 4'd7) begin
            k <= 4'd0;
            pass <= pass + 4'd1;
            state <= (pass == 4'd15) ? S_QRD : S_LOAD;
          end
        end
        S_QRD: begin
          mac_go <= 1'b1;
          state <= S_QDIV;
        end
        S_QDIV: begin
          mac_go <= 1'b0;
          if (status.div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            count <= count + 6'd1;
            state <= (count == 6'd63) ? S_COLLECT : S_QRD;
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

endmodule

[hw/rtl/jpeg_fdct_quantize_8x8_core.sv]
// ----------------------------------------------------------------------------
// jpeg_fdct_quantize_8x8_core
// 8x8 forward DCT with quality-scaled JPEG quantization.
// ----------------------------------------------------------------------------
// Samples of one block are taken one per cycle; after the 64th, sixteen row
// and column passes of a shared one-multiplier DCT unit run, each with 8
// loads and setup, a multiply sweep and 8 write-backs; then each of the 64
// coefficients goes through a read, a bit-serial step divide, a bit-serial
// level divide and the result, and is presented until taken. No input is
// accepted while a block is being transformed or delivered. Quality writes
// are taken at any time; write only while the block is idle.
module jpeg_fdct_quantize_8x8_core (
  input  logic clk,
  input  logic rst,
  jfq_in_if.sink    in_ch,
  jfq_out_if.source out_ch,
  jfq_cfg_if.sink   cfg
);
  import jfq_pkg::*;

  jfq_cmd_t    cmd;
  jfq_status_t status;
  logic [6:0]  quality;
  logic        table_sel;

  // hold the clamped quality register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      quality <= QUALITY_RESET;
    end else if (cfg.valid) begin
      quality <= (cfg.data == 7'd0) ? 7'd1 : (cfg.data > 7'd100) ? 7'd100 : cfg.data;
    end
  end

  assign out_ch.last = (out_ch.coeff_index == 6'd63);

  jfq_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_chroma(in_ch.is_chroma),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_index(out_ch.coeff_index), .table_sel(table_sel),
    .cmd(cmd), .status(status)
  );

  jfq_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .sample(in_ch.sample), .table_sel(table_sel), .quality(quality),
    .level(out_ch.level), .recon_value(out_ch.recon_value)
  );

  // no input is taken while results are pending
  assert property (@(posedge clk) disable iff (rst) !(in_ch.ready && out_ch.valid))
    else $error("input accepted during delivery");
  // quality stays within its range
  assert property (@(posedge clk) disable iff (rst) quality >= 7'd1 && quality <= 7'd100)
    else $error("quality out of range");
  // last coefficient returns the block to collection
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && out_ch.last |=> in_ch.ready)
    else $error("no return to collection after last result");

endmodule

[sim/jpeg_fdct_quantize_8x8_core_checker.sv]
// ----------------------------------------------------------------------------
// jpeg_fdct_quantize_8x8_core_checker
// Watches the sample, result and quality channels, predicts every quantized
// coefficient of each completed 8x8 block and compares it with the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jpeg_fdct_quantize_8x8_core_checker (
  input  logic clk,
  input  logic rst,
  jfq_in_if  in_ch,
  jfq_out_if out_ch,
  jfq_cfg_if cfg,
  output int errors,
  output int pending
);
  import jfq_pkg::*;

  typedef struct packed {
    logic [5:0]         coeff_index;
    logic signed [11:0] level;
    logic signed [12:0] recon_value;
    logic               last;
  } coeff_t;

  coeff_t coeff_q[$];
  longint pix_blk [64];
  logic [5:0] pix_cnt;
  logic [6:0] quality;

  function automatic longint frac_k(input longint k30);
    return (k30 + (longint'(1) << (29 - COEF_FRAC_BITS))) >>> (30 - COEF_FRAC_BITS);
  endfunction

  // round a fixed-point sum half away from zero
  function automatic longint round_away(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    return (v < 0) ? -m : m;
  endfunction

  function automatic int quant_step(input int base, input int q);
    int num, den, s;
    if (q < 50) begin
      num = 50 * base;
      den = q;
    end else begin
      num = base * (100 - q);
      den = 50;
    end
    s = (2 * num + den) / (2 * den);
    if (s < 1) s = 1;
    if (s > 255) s = 255;
    return s;
  endfunction

  function automatic int base_step(input bit chroma, input int i);
    int lt [64];
    lt = '{16,11,10,16,24,40,51,61, 12,12,14,19,26,58,60,55,
           14,13,16,24,40,57,69,56, 14,17,22,29,51,87,80,62,
           18,22,37,56,68,109,103,77, 24,35,55,64,81,104,113,92,
           49,64,78,87,103,121,120,101, 72,92,95,98,112,100,103,99};
    if (!chroma) return lt[i];
    case (i)
      0: return 17;  1: return 18;  2: return 24;  3: return 47;
      8: return 18;  9: return 21;  10: return 26; 11: return 66;
      16: return 24; 17: return 26; 18: return 56;
      24: return 47; 25: return 66;
      default: return 99;
    endcase
  endfunction

  // one 8-point DCT over blk[first + k*pitch]
  task automatic dct_line(ref longint blk [64], input int first, input int pitch);
    longint x [8];
    longint s0, s1, s2, s3, d0, d1, d2, d3, e0, e1, e2, e3;
    longint kn, ka, kb, kc, kd, ke, kf;
    kn = frac_k(K30_NORM); ka = frac_k(K30_A); kb = frac_k(K30_B);
    kc = frac_k(K30_C); kd = frac_k(K30_D); ke = frac_k(K30_E); kf = frac_k(K30_F);
    for (int k = 0; k < 8; k++) x[k] = blk[first + k * pitch];
    s0 = x[0] + x[7]; s1 = x[1] + x[6]; s2 = x[2] + x[5]; s3 = x[3] + x[4];
    d0 = x[0] - x[7]; d1 = x[6] - x[1]; d2 = x[2] - x[5]; d3 = x[4] - x[3];
    e0 = s0 + s3; e1 = s0 - s3; e2 = s1 + s2; e3 = s1 - s2;
    x[0] = round_away(kn * (e0 + e2));
    x[4] = round_away(kn * (e0 - e2));
    x[2] = round_away(kb * e1 + ke * e3);
    x[6] = round_away(ke * e1 - kb * e3);
    x[1] = round_away(ka * d0 - kc * d1 + kd * d2 - kf * d3);
    x[3] = round_away(kc * d0 + kf * d1 - ka * d2 + kd * d3);
    x[5] = round_away(kd * d0 + ka * d1 + kf * d2 - kc * d3);
    x[7] = round_away(kf * d0 + kd * d1 + kc * d2 + ka * d3);
    for (int k = 0; k < 8; k++) blk[first + k * pitch] = x[k];
  endtask

  // transform and quantize a full block, queue its 64 coefficients
  task automatic predict_block(input bit chroma);
    longint blk [64];
    longint c, m, lv, rv, st;
    coeff_t e;
    blk = pix_blk;
    for (int i = 0; i < 8; i++) dct_line(blk, i * 8, 1);
    for (int i = 0; i < 8; i++) dct_line(blk, i, 8);
    for (int i = 0; i < 64; i++) begin
      c = blk[i];
      st = quant_step(base_step(chroma, i), int'(quality));
      m = (c < 0) ? -c : c;
      lv = (2 * m + st) / (2 * st);
      if (c < 0) lv = -lv;
      if (lv > 2040) lv = 2040;
      if (lv < -2040) lv = -2040;
      rv = lv * st;
      if (rv > 2200) rv = 2200;
      if (rv < -2200) rv = -2200;
      e.coeff_index = 6'(i);
      e.level = 12'(lv);
      e.recon_value = 13'(rv);
      e.last = (i == 63);
      coeff_q.push_back(e);
    end
  endtask

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // track channels and compare results
  always @(posedge clk) begin
    coeff_t e;
    if (rst) begin
      pix_cnt <= '0;
      quality <= QUALITY_RESET;
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.data < 1) quality <= 7'd1;
        else if (cfg.data > 100) quality <= 7'd100;
        else quality <= cfg.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        pix_blk[pix_cnt] = longint'(in_ch.sample);
        if (pix_cnt == 6'd63) predict_block(in_ch.is_chroma);
        pix_cnt <= pix_cnt + 6'd1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (coeff_q.size() == 0) begin
          report($sformatf("unexpected result index %0d", out_ch.coeff_index));
        end else begin
          e = coeff_q.pop_front();
          if (out_ch.coeff_index !== e.coeff_index)
            report($sformatf("coeff_index %0d, want %0d", out_ch.coeff_index, e.coeff_index));
          if (out_ch.level !== e.level)
            report($sformatf("idx %0d level %0d, want %0d", e.coeff_index, out_ch.level,
                             e.level));
          if (out_ch.recon_value !== e.recon_value)
            report($sformatf("idx %0d recon_value %0d, want %0d", e.coeff_index,
                             out_ch.recon_value, e.recon_value));
          if (out_ch.last !== e.last)
            report($sformatf("idx %0d last %0b, want %0b", e.coeff_index, out_ch.last, e.last));
        end
      end
    end
    pending = coeff_q.size();
  end

endmodule

[sim/jpeg_fdct_quantize_8x8_core_tb.sv]
// ----------------------------------------------------------------------------
// jpeg_fdct_quantize_8x8_core_tb
// Feeds directed and random 8x8 blocks at several quality settings with bursty
// sample traffic and a stalling result sink; the checker gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jpeg_fdct_quantize_8x8_core_tb;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending, idle_cycles;
  bit   timed_out;

  jfq_in_if  in_ch ();
  jfq_out_if out_ch ();
  jfq_cfg_if cfg ();

  jpeg_fdct_quantize_8x8_core i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
  );

  jpeg_fdct_quantize_8x8_core_checker i_checker (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
    .errors(errors), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.is_chroma = 1'b0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
  end

  // result sink stalls in runs of its own
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if ($urandom_range(0, 7) == 0) out_ch.ready <= ~out_ch.ready;
    else if (!out_ch.ready && $urandom_range(0, 3) == 0) out_ch.ready <= 1'b1;
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready) || rst)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) timed_out = 1'b1;
  end

  always @(posedge clk) begin
    if (timed_out) begin
      $display("jpeg_fdct_quantize_8x8_core test failed");
      $finish;
    end
  end

  task automatic send_sample(input logic [7:0] s, input bit chroma, ref int burst);
    if (burst == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst = $urandom_range(1, 20);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.is_chroma <= chroma;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst--;
  endtask

  // pattern: 0 random, 1 flat min, 2 flat max, 3 checkerboard, 4 ramp
  task automatic send_block(input int pattern, input bit chroma, ref int burst);
    logic [7:0] s;
    for (int i = 0; i < 64; i++) begin
      case (pattern)
        1: s = 8'd0;
        2: s = 8'd255;
        3: s = (((i >> 3) ^ i) & 1) ? 8'd255 : 8'd0;
        4: s = 8'(i * 4);
        default: s = 8'($urandom_range(0, 255));
      endcase
      send_sample(s, chroma ^ (i != 63 && $urandom_range(0, 1)), burst);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_quality(input logic [6:0] q);
    cfg.valid <= 1'b1;
    cfg.data <= q;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    int burst;
    logic [6:0] qlist [6];
    qlist = '{7'd1, 7'd100, 7'd0, 7'd127, 7'd75, 7'd10};
    burst = 10;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed block at reset quality: a strong checkerboard
    send_block(3, 1'b0, burst);
    drain();
    // each quality setting, one block alternating luma and chroma
    foreach (qlist[k]) begin
      write_quality(qlist[k]);
      send_block(k < 4 ? k + 1 : 0, k[0], burst);
      drain();
    end
    if (errors == 0) begin
      $display("jpeg_fdct_quantize_8x8_core test passed");
    end else begin
      $display("jpeg_fdct_quantize_8x8_core test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/jfq_pkg.sv
hw/rtl/jfq_if.sv
hw/rtl/jfq_datapath.sv
hw/rtl/jfq_ctrl.sv
hw/rtl/jpeg_fdct_quantize_8x8_core.sv
sim/jpeg_fdct_quantize_8x8_core_checker.sv
sim/jpeg_fdct_quantize_8x8_core_tb.sv
